// File: sv/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies; imported by bcc_fsm and button_click_classifier.
package bcc_pkg;

   localparam int CNT_W  = 17;
   localparam int CFG_W  = 16;
   localparam int IDX_W  = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd288;
   localparam logic [CFG_W-1:0] LONG_RESET     = 16'd28846;
   localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd9615;

   localparam logic [IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [IDX_W-1:0] CSR_LONG     = 2'd1;
   localparam logic [IDX_W-1:0] CSR_WINDOW   = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_DEB1    = 3'd1,
      PH_HELD1   = 3'd2,
      PH_WINDOW  = 3'd3,
      PH_DEB2    = 3'd4,
      PH_WAITREL = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] long_press_ticks;
      logic [CFG_W-1:0] double_window_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] tick_count;
      logic [CNT_W-1:0] deb_count;
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

endpackage

// File: sv/bcc_fsm.sv
// One-tick step of the click state machine: next state and click event.
// Depends on bcc_pkg.
module bcc_fsm (
   input  bcc_pkg::state_type cur_state,
   input  bcc_pkg::cfg_type   cfg,
   input  logic               pressed,
   output bcc_pkg::state_type nxt_state,
   output bcc_pkg::event_type click_event
);
   import bcc_pkg::*;

   logic [CNT_W-1:0] tick_inc;
   logic [CNT_W-1:0] deb_inc;
   logic             deb_done1;
   logic             deb_done2;
   logic             long_hit;
   logic             window_hit;

   assign tick_inc   = sat_inc(cur_state.tick_count);
   assign deb_inc    = sat_inc(cur_state.deb_count);
   assign deb_done1  = tick_inc >= {1'b0, cfg.debounce_ticks};
   assign deb_done2  = deb_inc >= {1'b0, cfg.debounce_ticks};
   assign long_hit   = tick_inc >= {1'b0, cfg.long_press_ticks};
   assign window_hit = tick_inc >= {1'b0, cfg.double_window_ticks};

   always_comb begin
      nxt_state = cur_state;
      case (cur_state.phase)
         PH_DEB1: begin
            nxt_state.tick_count = tick_inc;
            if (deb_done1) nxt_state.phase = pressed ? PH_HELD1 : PH_IDLE;
         end
         PH_HELD1: begin
            nxt_state.tick_count = tick_inc;
            if (!pressed) nxt_state.phase = (long_hit || window_hit) ? PH_IDLE : PH_WINDOW;
         end
         PH_WINDOW: begin
            nxt_state.tick_count = tick_inc;
            if (window_hit) begin
               nxt_state.phase = PH_IDLE;
            end else if (pressed) begin
               nxt_state.deb_count = '0;
               nxt_state.phase     = PH_DEB2;
            end
         end
         PH_DEB2: begin
            nxt_state.tick_count = tick_inc;
            nxt_state.deb_count  = deb_inc;
            if (deb_done2) nxt_state.phase = pressed ? PH_WAITREL : PH_WINDOW;
         end
         PH_WAITREL: begin
            if (!pressed) nxt_state.phase = PH_IDLE;
         end
         default: begin
            if (pressed) begin
               nxt_state.tick_count = '0;
               nxt_state.phase      = PH_DEB1;
            end else begin
               nxt_state.phase = PH_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      click_event = EV_NONE;
      case (cur_state.phase)
         PH_HELD1: begin
            if (!pressed && long_hit)        click_event = EV_LONG;
            else if (!pressed && window_hit) click_event = EV_SINGLE;
         end
         PH_WINDOW: begin
            if (window_hit) click_event = EV_SINGLE;
         end
         PH_DEB2: begin
            if (deb_done2 && pressed) click_event = EV_DOUBLE;
         end
         default: click_event = EV_NONE;
      endcase
   end

endmodule

// File: sv/button_click_classifier.sv
// Top level of the button click classifier: beat registers, CSRs, state.
// Depends on bcc_pkg and bcc_fsm.
//
// Usage:
//   req_* carries one timer tick per beat: req_pressed is the sampled button
//   level (1 = pressed). rsp_* returns exactly one beat per tick with
//   rsp_click_event: 0 none, 1 single, 2 double, 3 long click.
//   A beat moves when valid is high and stall is low, on either channel.
//   csr_* writes the three thresholds (index 0 debounce, 1 long press,
//   2 double-click window); csr_ready is always high. Write only while idle.
// Timing:
//   An accepted tick is held in the input register, classified by one pass of
//   compare/increment logic and registered in the result register for rsp_*.
//   One tick per cycle is sustained while rsp_stall is low; the input register
//   and result register let a new tick in while the previous result waits.
// Reset: thresholds return to 288 / 28846 / 9615, phase goes idle, counters
//   clear, both beat registers empty.
// Stall: while rsp_stall holds a result and the input register is full,
//   req_stall rises; the held result does not change.
module button_click_classifier (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_pressed,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_click_event,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [bcc_pkg::IDX_W-1:0] csr_index,
   input  logic [bcc_pkg::CFG_W-1:0] csr_data
);
   import bcc_pkg::*;

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   event_type event_in;

   logic       in_valid_ff;
   logic       pressed_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_event_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_click_event = rsp_event_ff;

   bcc_fsm u_fsm (
      .cur_state   (state_ff),
      .cfg         (cfg_ff),
      .pressed     (pressed_ff),
      .nxt_state   (state_in),
      .click_event (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks    <= LONG_RESET;
         cfg_ff.double_window_ticks <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ticks      <= csr_data;
            CSR_LONG:     cfg_ff.long_press_ticks    <= csr_data;
            CSR_WINDOW:   cfg_ff.double_window_ticks <= csr_data;
            default:      ;
         endcase
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) pressed_ff <= req_pressed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.tick_count <= '0;
         state_ff.deb_count  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_event_ff <= event_in;
   end

endmodule
